### src/dvf_pkg.sv
// Shared types and constants for the 32-by-16 divider with flags and timing.
package dvf_pkg;

   // One restoring step per cell, one cell per quotient bit.
   localparam int NUM_CELLS = 16;

   // Cycle figures of the modeled divider, in half units where noted.
   localparam logic [7:0] CYC_ZERO_DIV   = 8'd38;
   localparam logic [7:0] CYC_UNS_OVF    = 8'd10;
   localparam logic [6:0] HALF_UNS_BASE  = 7'd38;
   localparam logic [6:0] HALF_SGN_EARLY = 7'd8;
   localparam logic [6:0] HALF_SGN_DNEG  = 7'd61;
   localparam logic [6:0] HALF_SGN_PNEG  = 7'd63;
   localparam logic [6:0] HALF_SGN_PPOS  = 7'd60;

   // Largest quotient magnitude that still fits when the quotient is negative.
   localparam logic [15:0] NEG_QUO_LIMIT = 16'h8000;

   // Request fields.
   typedef struct packed {
      logic        is_signed;
      logic [31:0] dividend;
      logic [15:0] divisor;
      logic        n_in;
      logic        z_in;
   } req_type;

   // Result fields.
   typedef struct packed {
      logic [31:0] dest_word;
      logic        dest_written;
      logic        flag_n;
      logic        flag_z;
      logic        flag_v;
      logic        flag_c;
      logic        zero_divide;
      logic [7:0]  core_cycles;
   } rsp_type;

   // Work carried from cell to cell along the divider chain.
   typedef struct packed {
      logic        is_signed;
      logic        neg_num;
      logic        neg_den;
      logic        zero_div;
      logic        ovf16;
      logic        early15;
      logic        n_in;
      logic        z_in;
      logic [15:0] aden;
      logic [15:0] rem;
      logic [15:0] low;
      logic [15:0] quo;
      logic [4:0]  acc;
   } stage_type;

endpackage

### src/dvf_prep.sv
// Front stage: operand magnitudes and early range checks.
module dvf_prep (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  dvf_pkg::req_type    in_req,
   output logic                out_valid,
   output dvf_pkg::stage_type  out_stage
);

   logic               valid_ff;
   dvf_pkg::stage_type stage_ff;
   dvf_pkg::stage_type stage_in;
   logic               neg_num;
   logic               neg_den;
   logic [31:0]        anum;
   logic [15:0]        aden;

   // Take magnitudes of signed operands and test whether the quotient fits.
   always_comb begin
      neg_num = in_req.is_signed & in_req.dividend[31];
      neg_den = in_req.is_signed & in_req.divisor[15];
      anum    = neg_num ? (~in_req.dividend) + 32'd1 : in_req.dividend;
      aden    = neg_den ? (~in_req.divisor) + 16'd1 : in_req.divisor;

      stage_in.is_signed = in_req.is_signed;
      stage_in.neg_num   = neg_num;
      stage_in.neg_den   = neg_den;
      stage_in.zero_div  = (in_req.divisor == 16'd0);
      stage_in.ovf16     = (anum[31:16] >= aden);
      stage_in.early15   = (anum[31:15] >= {1'b0, aden});
      stage_in.n_in      = in_req.n_in;
      stage_in.z_in      = in_req.z_in;
      stage_in.aden      = aden;
      stage_in.rem       = anum[31:16];
      stage_in.low       = anum[15:0];
      stage_in.quo       = 16'd0;
      stage_in.acc       = 5'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
   end

   assign out_valid = valid_ff;
   assign out_stage = stage_ff;

endmodule

### src/dvf_cell.sv
// One restoring division step with its share of the cycle count.
module dvf_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                count_en,
   input  logic                in_valid,
   input  dvf_pkg::stage_type  in_stage,
   output logic                out_valid,
   output dvf_pkg::stage_type  out_stage
);

   logic               valid_ff;
   dvf_pkg::stage_type stage_ff;
   dvf_pkg::stage_type stage_in;
   logic [16:0]        shifted;
   logic [16:0]        diff;
   logic               ge;
   logic               top;
   logic [1:0]         inc;

   // Shift in the next dividend bit and subtract the divisor when it fits.
   always_comb begin
      shifted = {in_stage.rem, in_stage.low[15]};
      diff    = shifted - {1'b0, in_stage.aden};
      ge      = (shifted >= {1'b0, in_stage.aden});
      top     = in_stage.rem[15];

      // Unsigned timing counts by the shifted-out bit; signed counts zero bits.
      if (!count_en) begin
         inc = 2'd0;
      end else if (in_stage.is_signed) begin
         inc = ge ? 2'd0 : 2'd1;
      end else if (top) begin
         inc = 2'd0;
      end else begin
         inc = ge ? 2'd1 : 2'd2;
      end

      stage_in     = in_stage;
      stage_in.rem = ge ? diff[15:0] : shifted[15:0];
      stage_in.low = {in_stage.low[14:0], 1'b0};
      stage_in.quo = {in_stage.quo[14:0], ge};
      stage_in.acc = in_stage.acc + {3'd0, inc};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
   end

   assign out_valid = valid_ff;
   assign out_stage = stage_ff;

endmodule

### src/dvf_final.sv
// Final stage: sign correction, overflow, flags and cycle count.
module dvf_final (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  dvf_pkg::stage_type  in_stage,
   output logic                out_valid,
   output dvf_pkg::rsp_type    out_rsp
);

   logic             valid_ff;
   dvf_pkg::rsp_type rsp_ff;
   dvf_pkg::rsp_type rsp_in;
   logic             q_neg;
   logic [15:0]      q16;
   logic [15:0]      r16;
   logic             ovf;
   logic [6:0]       half;
   logic [7:0]       cycles;

   always_comb begin
      // Restore the signs of quotient and remainder.
      q_neg = in_stage.neg_num ^ in_stage.neg_den;
      q16   = q_neg ? (~in_stage.quo) + 16'd1 : in_stage.quo;
      r16   = in_stage.neg_num ? (~in_stage.rem) + 16'd1 : in_stage.rem;

      // A signed quotient must also fit the 16-bit two's complement range.
      ovf = in_stage.ovf16 |
            (in_stage.is_signed &
             (q_neg ? (in_stage.quo > dvf_pkg::NEG_QUO_LIMIT) : in_stage.quo[15]));

      // Cycle count, kept in half units until the final doubling.
      if (in_stage.is_signed) begin
         if (in_stage.early15) begin
            half = dvf_pkg::HALF_SGN_EARLY + {6'd0, in_stage.neg_num};
         end else if (in_stage.neg_den) begin
            half = dvf_pkg::HALF_SGN_DNEG + {6'd0, in_stage.neg_num} + {2'd0, in_stage.acc};
         end else if (in_stage.neg_num) begin
            half = dvf_pkg::HALF_SGN_PNEG + {2'd0, in_stage.acc};
         end else begin
            half = dvf_pkg::HALF_SGN_PPOS + {2'd0, in_stage.acc};
         end
      end else begin
         half = dvf_pkg::HALF_UNS_BASE + {2'd0, in_stage.acc};
      end

      if (in_stage.zero_div) begin
         cycles = dvf_pkg::CYC_ZERO_DIV;
      end else if (!in_stage.is_signed && in_stage.ovf16) begin
         cycles = dvf_pkg::CYC_UNS_OVF;
      end else begin
         cycles = {half, 1'b0};
      end

      // Pick the outcome: zero divide, overflow or a written result.
      rsp_in.flag_c      = 1'b0;
      rsp_in.core_cycles = cycles;
      if (in_stage.zero_div) begin
         rsp_in.dest_word    = 32'd0;
         rsp_in.dest_written = 1'b0;
         rsp_in.flag_n       = 1'b0;
         rsp_in.flag_z       = 1'b0;
         rsp_in.flag_v       = 1'b0;
         rsp_in.zero_divide  = 1'b1;
      end else if (ovf) begin
         rsp_in.dest_word    = 32'd0;
         rsp_in.dest_written = 1'b0;
         rsp_in.flag_n       = in_stage.n_in;
         rsp_in.flag_z       = in_stage.z_in;
         rsp_in.flag_v       = 1'b1;
         rsp_in.zero_divide  = 1'b0;
      end else begin
         rsp_in.dest_word    = {r16, q16};
         rsp_in.dest_written = 1'b1;
         rsp_in.flag_n       = q16[15];
         rsp_in.flag_z       = (q16 == 16'd0);
         rsp_in.flag_v       = 1'b0;
         rsp_in.zero_divide  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign out_valid = valid_ff;
   assign out_rsp   = rsp_ff;

endmodule

### src/div32by16_flags_timing_unit.sv
// Top level of the pipelined 32-by-16 divider with flags and timing count.
//
//   channel   handshake          payload     direction
//   request   start / busy       req_data    in
//   response  rsp_strobe         rsp_data    out
//
// A request is taken at any edge where start is high; busy is always low.
// Each request passes a front stage, a chain of 16 divider cells (one
// quotient bit per cell) and a final stage, each registered, with one
// request per cycle sustained. The response shows for one cycle under
// rsp_strobe; the receiver cannot stall it. Synchronous reset empties the chain.
module div32by16_flags_timing_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  dvf_pkg::req_type  req_data,
   output logic              rsp_strobe,
   output dvf_pkg::rsp_type  rsp_data
);

   logic               valid_chain [dvf_pkg::NUM_CELLS+1];
   dvf_pkg::stage_type stage_chain [dvf_pkg::NUM_CELLS+1];

   // The pipeline never holds off a request.
   assign busy = 1'b0;

   dvf_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start),
      .in_req    (req_data),
      .out_valid (valid_chain[0]),
      .out_stage (stage_chain[0])
   );

   // Chain of restoring cells; the last one does not add to the timing count.
   for (genvar i = 0; i < dvf_pkg::NUM_CELLS; i++) begin : g_cell
      dvf_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .count_en  ((i < dvf_pkg::NUM_CELLS - 1) ? 1'b1 : 1'b0),
         .in_valid  (valid_chain[i]),
         .in_stage  (stage_chain[i]),
         .out_valid (valid_chain[i+1]),
         .out_stage (stage_chain[i+1])
      );
   end

   dvf_final u_final (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (valid_chain[dvf_pkg::NUM_CELLS]),
      .in_stage  (stage_chain[dvf_pkg::NUM_CELLS]),
      .out_valid (rsp_strobe),
      .out_rsp   (rsp_data)
   );

`ifndef SYNTHESIS
   // Every request comes out a fixed number of cycles later.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      start |-> ##18 rsp_strobe)
      else $error("response missing at fixed latency");

   // Written result, overflow and zero divide exclude each other.
   a_outcome: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $onehot0({rsp_data.dest_written, rsp_data.flag_v,
                               rsp_data.zero_divide}))
      else $error("conflicting response outcome");

   // Reset empties the whole chain.
   a_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_strobe)
      else $error("response right after reset");

   // A response that is not written carries an empty word.
   a_unwritten: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.dest_written |-> rsp_data.dest_word == 32'd0)
      else $error("unwritten response carries data");
`endif

endmodule

### test/div32by16_flags_timing_checker.sv
// Channel monitor that predicts each divider response and compares it field by field.
`timescale 1ns / 1ps
module div32by16_flags_timing_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             busy,
   input  dvf_pkg::req_type req_data,
   input  logic             rsp_strobe,
   input  dvf_pkg::rsp_type rsp_data,
   output int               outstanding,
   output int               fail_count,
   output int               checked_count,
   output int               signed_count,
   output int               zero_div_count,
   output int               overflow_count
);

   // Timing figures of the modeled restoring divider.
   localparam logic [7:0] ZERO_DIV_CYCLES  = 8'd38;
   localparam logic [7:0] UNS_OVF_CYCLES   = 8'd10;
   localparam int         UNS_START_HALVES = 38;
   localparam int         SGN_START_HALVES = 6;
   localparam int         SGN_LONG_HALVES  = 55;
   localparam int         MAX_PRINTED      = 100;

   // One accepted request together with the response it must produce.
   typedef struct packed {
      dvf_pkg::req_type req;
      dvf_pkg::rsp_type want;
      logic [31:0]      seq;
   } division_type;

   division_type awaiting_q[$];
   int           seq_count = 0;

   initial begin
      outstanding    = 0;
      fail_count     = 0;
      checked_count  = 0;
      signed_count   = 0;
      zero_div_count = 0;
      overflow_count = 0;
   end

   // Unsigned divider timing: 15 shift steps against the divisor in the upper half.
   function automatic logic [7:0] unsigned_timing(logic [31:0] num, logic [15:0] den);
      logic [31:0] work;
      logic [31:0] shifted_den;
      int          halves;
      if (num[31:16] >= den) return UNS_OVF_CYCLES;
      work        = num;
      shifted_den = {den, 16'h0000};
      halves      = UNS_START_HALVES;
      for (int i = 0; i < 15; i++) begin
         if (work[31]) begin
            work = (work << 1) - shifted_den;
         end else begin
            work   = work << 1;
            halves += 2;
            if (work >= shifted_den) begin
               work   -= shifted_den;
               halves -= 1;
            end
         end
      end
      return 8'(halves * 2);
   endfunction

   // Signed divider timing, driven by the magnitudes and the zero bits of the quotient.
   function automatic logic [7:0] signed_timing(longint num, longint den);
      longint anum;
      longint aden;
      longint aquot;
      int     halves;
      halves = SGN_START_HALVES + ((num < 0) ? 1 : 0);
      anum   = (num < 0) ? -num : num;
      aden   = (den < 0) ? -den : den;
      // A quotient that clearly cannot fit ends the operation early.
      if ((anum >> 15) >= aden) return 8'((halves + 2) * 2);
      aquot  = anum / aden;
      halves += SGN_LONG_HALVES;
      if (den >= 0) halves += (num >= 0) ? -1 : 1;
      for (int b = 15; b >= 1; b--) begin
         if (!aquot[b]) halves++;
      end
      return 8'(halves * 2);
   endfunction

   // Expected response for one request.
   function automatic dvf_pkg::rsp_type divide_with_flags(dvf_pkg::req_type r);
      dvf_pkg::rsp_type res;
      logic [31:0]      uquo;
      longint           snum;
      longint           sden;
      longint           quo;
      longint           rem;
      logic [15:0]      q16;
      logic [15:0]      r16;
      res = '0;
      q16 = '0;
      r16 = '0;
      if (r.divisor == 16'h0000) begin
         res.zero_divide = 1'b1;
         res.core_cycles = ZERO_DIV_CYCLES;
      end else if (!r.is_signed) begin
         uquo            = r.dividend / r.divisor;
         res.core_cycles = unsigned_timing(r.dividend, r.divisor);
         if (uquo > 32'h0000_FFFF) begin
            res.flag_v = 1'b1;
            res.flag_n = r.n_in;
            res.flag_z = r.z_in;
         end else begin
            res.dest_written = 1'b1;
            q16              = uquo[15:0];
            r16              = 16'(r.dividend % r.divisor);
         end
      end else begin
         snum            = longint'($signed(r.dividend));
         sden            = longint'($signed(r.divisor));
         quo             = snum / sden;
         rem             = snum % sden;
         res.core_cycles = signed_timing(snum, sden);
         if (quo > 32767 || quo < -32768) begin
            res.flag_v = 1'b1;
            res.flag_n = r.n_in;
            res.flag_z = r.z_in;
         end else begin
            res.dest_written = 1'b1;
            q16              = quo[15:0];
            r16              = rem[15:0];
         end
      end
      // A written result sets N and Z from the 16-bit quotient.
      if (res.dest_written) begin
         res.dest_word = {r16, q16};
         res.flag_n    = q16[15];
         res.flag_z    = (q16 == 16'h0000);
      end
      return res;
   endfunction

   // Print one mismatch line (up to a cap) and count it.
   task automatic report_mismatch(string msg);
      if (fail_count < MAX_PRINTED) $display("%0t  %s", $time, msg);
      fail_count++;
   endtask

   task automatic compare_field(string field, logic [31:0] got, logic [31:0] want,
                                division_type d);
      if (got !== want) begin
         report_mismatch($sformatf("request %0d (%s %h / %h): %s is %h, expected %h",
                                   d.seq, d.req.is_signed ? "signed" : "unsigned",
                                   d.req.dividend, d.req.divisor, field, got, want));
      end
   endtask

   // Record accepted requests and check each strobed response against the oldest one.
   always @(posedge clock) begin : watch_channels
      division_type entry;
      if (!reset) begin
         if (start && !busy) begin
            entry.req  = req_data;
            entry.want = divide_with_flags(req_data);
            entry.seq  = seq_count;
            awaiting_q.push_back(entry);
            seq_count++;
         end
         if (rsp_strobe) begin
            if (awaiting_q.size() == 0) begin
               report_mismatch("response arrived with no request outstanding");
            end else begin
               entry = awaiting_q.pop_front();
               compare_field("dest_word", rsp_data.dest_word, entry.want.dest_word, entry);
               compare_field("dest_written", rsp_data.dest_written, entry.want.dest_written,
                             entry);
               compare_field("flag_n", rsp_data.flag_n, entry.want.flag_n, entry);
               compare_field("flag_z", rsp_data.flag_z, entry.want.flag_z, entry);
               compare_field("flag_v", rsp_data.flag_v, entry.want.flag_v, entry);
               compare_field("flag_c", rsp_data.flag_c, entry.want.flag_c, entry);
               compare_field("zero_divide", rsp_data.zero_divide, entry.want.zero_divide,
                             entry);
               compare_field("core_cycles", rsp_data.core_cycles, entry.want.core_cycles,
                             entry);
               checked_count++;
               if (entry.req.is_signed) signed_count++;
               if (entry.want.zero_divide) zero_div_count++;
               if (entry.want.flag_v) overflow_count++;
            end
         end
      end
      outstanding <= awaiting_q.size();
   end

endmodule

### test/div32by16_flags_timing_unit_tb.sv
// Testbench top for the 32-by-16 divider: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps
module div32by16_flags_timing_unit_tb;

   localparam int RANDOM_REQUESTS = 1600;
   localparam int DRAIN_POINT     = 800;
   localparam int IDLE_LIMIT      = 1000;
   localparam int SETTLE_CYCLES   = 40;

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   dvf_pkg::req_type req_data;
   logic             rsp_strobe;
   dvf_pkg::rsp_type rsp_data;

   int outstanding;
   int fail_count;
   int checked_count;
   int signed_count;
   int zero_div_count;
   int overflow_count;
   int idle_cycles = 0;

   div32by16_flags_timing_unit dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   div32by16_flags_timing_checker result_check (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_data       (req_data),
      .rsp_strobe     (rsp_strobe),
      .rsp_data       (rsp_data),
      .outstanding    (outstanding),
      .fail_count     (fail_count),
      .checked_count  (checked_count),
      .signed_count   (signed_count),
      .zero_div_count (zero_div_count),
      .overflow_count (overflow_count)
   );

   // 2 ns clock.
   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // Watchdog: end the run when neither channel moves for too long.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Timed out after %0d cycles without a request or response.", IDLE_LIMIT);
         $display("CHECK FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic logic coin();
      return 1'($urandom_range(1));
   endfunction

   function automatic dvf_pkg::req_type pack_request(logic sgn, logic [31:0] num,
                                                     logic [15:0] den, logic n, logic z);
      dvf_pkg::req_type r;
      r.is_signed = sgn;
      r.dividend  = num;
      r.divisor   = den;
      r.n_in      = n;
      r.z_in      = z;
      return r;
   endfunction

   // Unsigned request with a chosen quotient and a random legal remainder.
   function automatic dvf_pkg::req_type unsigned_case(logic [31:0] quo, logic [31:0] den);
      logic [31:0] rem;
      rem = $urandom % den;
      return pack_request(1'b0, quo * den + rem, den[15:0], coin(), coin());
   endfunction

   // Signed request with a chosen quotient; the remainder takes the dividend's sign.
   function automatic dvf_pkg::req_type signed_case(longint quo, longint den);
      longint rem_mag;
      longint num;
      logic   neg;
      rem_mag = longint'($urandom) % ((den < 0) ? -den : den);
      neg     = (quo != 0) ? ((quo < 0) != (den < 0)) : coin();
      num     = quo * den + (neg ? -rem_mag : rem_mag);
      return pack_request(1'b1, num[31:0], den[15:0], coin(), coin());
   endfunction

   // Divisors spread over all magnitudes.
   function automatic logic [31:0] pick_unsigned_divisor();
      logic [31:0] d;
      d = $urandom_range(1, 65535) >> $urandom_range(15);
      if (d == 0) d = 1;
      return d;
   endfunction

   function automatic longint pick_signed_divisor();
      longint mag;
      mag = longint'($urandom_range(1, 32768)) >> $urandom_range(15);
      if (mag == 0) mag = 1;
      if (mag == 32768 || coin()) return -mag;
      return mag;
   endfunction

   function automatic longint pick_signed_quotient();
      logic signed [15:0] q;
      q = 16'($urandom);
      return longint'(q >>> $urandom_range(15));
   endfunction

   // Mix of request shapes: mostly quotients that fit, plus noise and edge cases.
   function automatic dvf_pkg::req_type random_request();
      int     kind;
      longint sden;
      kind = $urandom_range(99);
      if (kind < 10) begin
         // Divide by zero with any dividend.
         return pack_request(coin(), $urandom, 16'h0000, coin(), coin());
      end else if (kind < 25) begin
         // Raw fields: mostly overflow, and every bit of every field moves.
         return pack_request(coin(), $urandom, 16'($urandom), coin(), coin());
      end else if (kind < 35) begin
         // Quotients just inside and just outside the 16-bit range.
         case ($urandom_range(5))
            0:       return unsigned_case(32'h0000_FFFF, pick_unsigned_divisor());
            1:       return unsigned_case(32'h0001_0000, pick_unsigned_divisor());
            2:       return signed_case(32767, pick_signed_divisor());
            3:       return signed_case(32768, pick_signed_divisor());
            4:       return signed_case(-32768, pick_signed_divisor());
            default: return signed_case(-32769, pick_signed_divisor());
         endcase
      end else if (kind < 45) begin
         // Tiny operands.
         if (coin()) return unsigned_case($urandom_range(40), $urandom_range(1, 15));
         sden = $urandom_range(1, 15);
         if (coin()) sden = -sden;
         return signed_case(longint'($urandom_range(80)) - 40, sden);
      end else if (coin()) begin
         return unsigned_case(32'($urandom_range(16'hFFFF)) >> $urandom_range(15),
                              pick_unsigned_divisor());
      end
      return signed_case(pick_signed_quotient(), pick_signed_divisor());
   endfunction

   // Present one request and hold it until the block takes it.
   task automatic issue(input dvf_pkg::req_type r);
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy !== 1'b0);
   endtask

   // Stop sending and wait for every outstanding response.
   task automatic wait_for_results();
      start <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   initial begin : stimulus
      int sent;
      int burst;
      int gap;
      reset    = 1'b1;
      start    = 1'b0;
      req_data = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed requests: zero divide, overflow edges and remainder signs.
      issue(pack_request(1'b0, 32'h0000_0000, 16'h0000, 1'b1, 1'b1));
      issue(pack_request(1'b1, 32'h8000_0000, 16'h0000, 1'b0, 1'b1));
      issue(pack_request(1'b0, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 1'b0));
      issue(pack_request(1'b0, 32'hFFFE_0001, 16'hFFFF, 1'b0, 1'b0));
      issue(pack_request(1'b0, 32'h0000_0000, 16'h0001, 1'b1, 1'b0));
      issue(pack_request(1'b0, 32'h0000_FFFF, 16'h0001, 1'b0, 1'b1));
      issue(pack_request(1'b0, 32'h0001_0000, 16'h0001, 1'b1, 1'b1));
      issue(pack_request(1'b0, 32'h00BC_614E, 16'h1234, 1'b0, 1'b0));
      issue(pack_request(1'b0, 32'h0000_0064, 16'h0007, 1'b1, 1'b1));
      // Most negative dividend by minus one.
      issue(pack_request(1'b1, 32'h8000_0000, 16'hFFFF, 1'b1, 1'b0));
      issue(pack_request(1'b1, 32'hFFFF_8000, 16'h0001, 1'b0, 1'b1));
      issue(pack_request(1'b1, 32'h0000_8000, 16'hFFFF, 1'b0, 1'b0));
      issue(pack_request(1'b1, 32'h0000_8000, 16'h0001, 1'b1, 1'b1));
      issue(pack_request(1'b1, 32'h0000_7FFF, 16'h0001, 1'b0, 1'b0));
      // Remainder follows the sign of the dividend.
      issue(pack_request(1'b1, 32'hFFFF_FFF9, 16'h0002, 1'b0, 1'b0));
      issue(pack_request(1'b1, 32'h0000_0007, 16'hFFFE, 1'b1, 1'b0));
      issue(pack_request(1'b1, 32'hFFFF_FFF9, 16'hFFFE, 1'b0, 1'b1));
      issue(pack_request(1'b1, 32'h7FFF_FFFF, 16'h7FFF, 1'b1, 1'b1));
      issue(pack_request(1'b1, 32'h0000_0000, 16'h8000, 1'b1, 1'b0));
      issue(pack_request(1'b1, 32'hC000_0000, 16'h8000, 1'b0, 1'b1));
      issue(pack_request(1'b1, 32'h3FFF_8000, 16'h8000, 1'b1, 1'b1));
      issue(pack_request(1'b1, 32'h8000_0000, 16'h8000, 1'b0, 1'b0));
      issue(pack_request(1'b1, 32'h8000_0000, 16'h7FFF, 1'b1, 1'b0));
      wait_for_results();

      // Random requests in bursts with random gaps; drain fully once midway.
      sent = 0;
      while (sent < RANDOM_REQUESTS) begin
         burst = ($urandom_range(7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
         for (int k = 0; k < burst && sent < RANDOM_REQUESTS; k++) begin
            issue(random_request());
            sent++;
            if (sent == DRAIN_POINT) wait_for_results();
         end
         gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 20);
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Compared %0d division results: %0d signed, %0d unsigned.",
               checked_count, signed_count, checked_count - signed_count);
      $display("Among them %0d divide-by-zero and %0d quotient overflows; %0d mismatches.",
               zero_div_count, overflow_count, fail_count);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
